FILE: design/rmth_pkg.sv
`default_nettype none
package rmth_pkg;

   localparam int HEAP_DEPTH_DEF = 512;
   localparam int VALUE_W        = 32;
   localparam int MEDIAN_W       = 33;
   localparam int COUNT_W        = 10;
   localparam int OP_W           = 4;

   // Datapath operation codes issued by the controller.
   localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD        = 4'd1;
   localparam logic [OP_W-1:0] OP_PUSH_INIT   = 4'd2;
   localparam logic [OP_W-1:0] OP_PUSH_READ   = 4'd3;
   localparam logic [OP_W-1:0] OP_PUSH_WRITE  = 4'd4;
   localparam logic [OP_W-1:0] OP_PUSH_MOVE   = 4'd5;
   localparam logic [OP_W-1:0] OP_POP_INIT    = 4'd6;
   localparam logic [OP_W-1:0] OP_POP_RLAST   = 4'd7;
   localparam logic [OP_W-1:0] OP_POP_LAST    = 4'd8;
   localparam logic [OP_W-1:0] OP_POP_READ_C  = 4'd9;
   localparam logic [OP_W-1:0] OP_POP_RC      = 4'd10;
   localparam logic [OP_W-1:0] OP_POP_RC1     = 4'd11;
   localparam logic [OP_W-1:0] OP_POP_WLAST   = 4'd12;
   localparam logic [OP_W-1:0] OP_POP_MOVE    = 4'd13;
   localparam logic [OP_W-1:0] OP_XFER        = 4'd14;
   localparam logic [OP_W-1:0] OP_RESP        = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            pop_sel;   // 0: lower (max) heap, 1: upper (min) heap
   } cmd_type;

   typedef struct packed {
      logic full;
      logic i_zero;
      logic val_above;
      logic n_zero;
      logic c_ge_n;
      logic c1_lt_n;
      logic rdata_above_hc;
      logic hc_above_last;
      logic lower_big;
      logic upper_big;
      logic rsp_free;
   } stat_type;

   // True when a must sit above b: max-heap for the lower half, min-heap above.
   function automatic logic ranks_above(input logic signed [VALUE_W-1:0] a,
                                        input logic signed [VALUE_W-1:0] b,
                                        input logic                      is_upper);
      ranks_above = is_upper ? (a < b) : (a > b);
   endfunction

endpackage
`default_nettype wire

FILE: design/rmth_req_if.sv
`default_nettype none
interface rmth_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rmth_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: design/rmth_rsp_if.sv
`default_nettype none
interface rmth_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rmth_pkg::MEDIAN_W-1:0] median_doubled;
   logic [rmth_pkg::COUNT_W-1:0]         element_count;
   logic                                 dropped;

   modport source (output valid, output median_doubled, output element_count,
                   output dropped, input ready);
   modport sink   (input valid, input median_doubled, input element_count,
                   input dropped, output ready);
endinterface
`default_nettype wire

FILE: design/rmth_ctrl.sv
`default_nettype none
module rmth_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  rmth_pkg::stat_type     stat,
   output rmth_pkg::cmd_type      cmd
);
   import rmth_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_PUSH_INIT = 4'd1;
   localparam logic [3:0] S_PUSH_CHK  = 4'd2;
   localparam logic [3:0] S_PUSH_CMP  = 4'd3;
   localparam logic [3:0] S_REBAL     = 4'd4;
   localparam logic [3:0] S_POP_N     = 4'd5;
   localparam logic [3:0] S_POP_LAST  = 4'd6;
   localparam logic [3:0] S_POP_CHK   = 4'd7;
   localparam logic [3:0] S_POP_RC    = 4'd8;
   localparam logic [3:0] S_POP_RC1   = 4'd9;
   localparam logic [3:0] S_POP_CMP   = 4'd10;
   localparam logic [3:0] S_XFER      = 4'd11;
   localparam logic [3:0] S_RESP      = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       phase_ff, phase_in;   // high once the rebalance move has begun
   logic [3:0] after_push;

   assign after_push = phase_ff ? S_RESP : S_REBAL;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cmd.op      = OP_NONE;
      cmd.pop_sel = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               phase_in = 1'b0;
               state_in = stat.full ? S_RESP : S_PUSH_INIT;
            end
         end
         S_PUSH_INIT: begin
            cmd.op   = OP_PUSH_INIT;
            state_in = S_PUSH_CHK;
         end
         S_PUSH_CHK: begin
            if (stat.i_zero) begin
               cmd.op   = OP_PUSH_WRITE;
               state_in = after_push;
            end else begin
               cmd.op   = OP_PUSH_READ;
               state_in = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            if (stat.val_above) begin
               cmd.op   = OP_PUSH_MOVE;
               state_in = S_PUSH_CHK;
            end else begin
               cmd.op   = OP_PUSH_WRITE;
               state_in = after_push;
            end
         end
         S_REBAL: begin
            phase_in = 1'b1;
            if (stat.lower_big) begin
               cmd.op      = OP_POP_INIT;
               cmd.pop_sel = 1'b0;
               state_in    = S_POP_N;
            end else if (stat.upper_big) begin
               cmd.op      = OP_POP_INIT;
               cmd.pop_sel = 1'b1;
               state_in    = S_POP_N;
            end else begin
               state_in = S_RESP;
            end
         end
         S_POP_N: begin
            if (stat.n_zero) begin
               cmd.op   = OP_XFER;
               state_in = S_PUSH_INIT;
            end else begin
               cmd.op   = OP_POP_RLAST;
               state_in = S_POP_LAST;
            end
         end
         S_POP_LAST: begin
            cmd.op   = OP_POP_LAST;
            state_in = S_POP_CHK;
         end
         S_POP_CHK: begin
            if (stat.c_ge_n) begin
               cmd.op   = OP_POP_WLAST;
               state_in = S_XFER;
            end else begin
               cmd.op   = OP_POP_READ_C;
               state_in = S_POP_RC;
            end
         end
         S_POP_RC: begin
            cmd.op   = OP_POP_RC;
            state_in = stat.c1_lt_n ? S_POP_RC1 : S_POP_CMP;
         end
         S_POP_RC1: begin
            cmd.op   = OP_POP_RC1;
            state_in = S_POP_CMP;
         end
         S_POP_CMP: begin
            if (stat.hc_above_last) begin
               cmd.op   = OP_POP_MOVE;
               state_in = S_POP_CHK;
            end else begin
               cmd.op   = OP_POP_WLAST;
               state_in = S_XFER;
            end
         end
         S_XFER: begin
            cmd.op   = OP_XFER;
            state_in = S_PUSH_INIT;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_RESP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/rmth_dpath.sv
`default_nettype none
module rmth_dpath #(
   parameter int HEAP_DEPTH = rmth_pkg::HEAP_DEPTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  rmth_pkg::cmd_type                         cmd,
   output rmth_pkg::stat_type                        stat,
   input  wire logic signed [rmth_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_valid,
   output logic signed [rmth_pkg::MEDIAN_W-1:0]      rsp_median_doubled,
   output logic [rmth_pkg::COUNT_W-1:0]              rsp_element_count,
   output logic                                      rsp_dropped
);
   import rmth_pkg::*;

   localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int SW = $clog2(HEAP_DEPTH + 1);
   localparam logic [SW:0] CAPACITY = (SW+1)'(2 * HEAP_DEPTH - 1);

   logic signed [VALUE_W-1:0] lo_mem [HEAP_DEPTH];
   logic signed [VALUE_W-1:0] up_mem [HEAP_DEPTH];
   logic signed [VALUE_W-1:0] lo_rd_ff, up_rd_ff, rdata;

   logic                      sel_ff;
   logic signed [VALUE_W-1:0] val_ff, last_ff, hc_ff, lo_top_ff, up_top_ff;
   logic [SW-1:0]             lower_size_ff, upper_size_ff, size_sel, size_pop;
   logic [IW-1:0]             i_ff, n_ff, c_ff;
   logic                      drop_ff;

   logic [IW:0]               c_wide;
   logic [IW+1:0]             c1_wide;
   logic [IW-1:0]             parent;
   logic [SW:0]               total;

   logic                      we;
   logic [IW-1:0]             waddr, raddr;
   logic signed [VALUE_W-1:0] wdata;

   logic signed [MEDIAN_W-1:0] lo_ext, hi_ext, median;

   assign rdata    = sel_ff ? up_rd_ff : lo_rd_ff;
   assign size_sel = sel_ff ? upper_size_ff : lower_size_ff;
   assign size_pop = cmd.pop_sel ? upper_size_ff : lower_size_ff;
   assign c_wide   = {i_ff, 1'b1};
   assign c1_wide  = {1'b0, c_wide} + (IW+2)'(1);
   assign parent   = (i_ff - IW'(1)) >> 1;
   assign total    = {1'b0, lower_size_ff} + {1'b0, upper_size_ff};

   always_comb begin
      stat.full           = (total >= CAPACITY);
      stat.i_zero         = (i_ff == '0);
      stat.val_above      = ranks_above(val_ff, rdata, sel_ff);
      stat.n_zero         = (n_ff == '0);
      stat.c_ge_n         = (c_wide >= {1'b0, n_ff});
      stat.c1_lt_n        = (c1_wide < {2'b00, n_ff});
      stat.rdata_above_hc = ranks_above(rdata, hc_ff, sel_ff);
      stat.hc_above_last  = ranks_above(hc_ff, last_ff, sel_ff);
      stat.lower_big      = ({1'b0, lower_size_ff} > ({1'b0, upper_size_ff} + (SW+1)'(1)));
      stat.upper_big      = (upper_size_ff > lower_size_ff);
      stat.rsp_free       = !rsp_valid || rsp_ready;
   end

   // Memory port selection.
   always_comb begin
      we    = 1'b0;
      waddr = i_ff;
      wdata = val_ff;
      raddr = parent;
      case (cmd.op)
         OP_PUSH_WRITE: we = 1'b1;
         OP_PUSH_MOVE: begin
            we    = 1'b1;
            wdata = rdata;
         end
         OP_POP_WLAST: begin
            we    = 1'b1;
            wdata = last_ff;
         end
         OP_POP_MOVE: begin
            we    = 1'b1;
            wdata = hc_ff;
         end
         OP_POP_RLAST:  raddr = n_ff;
         OP_POP_READ_C: raddr = c_wide[IW-1:0];
         OP_POP_RC:     raddr = c1_wide[IW-1:0];
         default:       raddr = parent;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we && !sel_ff) begin
         lo_mem[waddr] <= wdata;
      end
      if (we && sel_ff) begin
         up_mem[waddr] <= wdata;
      end
      lo_rd_ff <= lo_mem[raddr];
      up_rd_ff <= up_mem[raddr];
   end

   always_comb begin
      lo_ext = (lower_size_ff != '0) ? MEDIAN_W'(lo_top_ff) : '0;
      hi_ext = (upper_size_ff != '0) ? MEDIAN_W'(up_top_ff) : '0;
      median = (lower_size_ff == upper_size_ff) ? (lo_ext + hi_ext) : (lo_ext <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_size_ff <= '0;
         upper_size_ff <= '0;
         rsp_valid     <= 1'b0;
      end else begin
         case (cmd.op)
            OP_PUSH_INIT: begin
               if (sel_ff) upper_size_ff <= upper_size_ff + SW'(1);
               else        lower_size_ff <= lower_size_ff + SW'(1);
            end
            OP_POP_INIT: begin
               if (cmd.pop_sel) upper_size_ff <= upper_size_ff - SW'(1);
               else             lower_size_ff <= lower_size_ff - SW'(1);
            end
            default: begin
            end
         endcase
         if (cmd.op == OP_RESP) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we && waddr == '0) begin
         if (sel_ff) up_top_ff <= wdata;
         else        lo_top_ff <= wdata;
      end
      case (cmd.op)
         OP_LOAD: begin
            val_ff  <= req_value;
            drop_ff <= stat.full;
            sel_ff  <= !((lower_size_ff == '0) || (req_value <= lo_top_ff));
         end
         OP_PUSH_INIT: i_ff <= IW'(size_sel);
         OP_PUSH_MOVE: i_ff <= parent;
         OP_POP_INIT: begin
            sel_ff <= cmd.pop_sel;
            val_ff <= cmd.pop_sel ? up_top_ff : lo_top_ff;
            n_ff   <= IW'(size_pop - SW'(1));
            i_ff   <= '0;
         end
         OP_POP_LAST: last_ff <= rdata;
         OP_POP_RC: begin
            hc_ff <= rdata;
            c_ff  <= c_wide[IW-1:0];
         end
         OP_POP_RC1: begin
            if (stat.rdata_above_hc) begin
               hc_ff <= rdata;
               c_ff  <= c_ff + IW'(1);
            end
         end
         OP_POP_MOVE: i_ff <= c_ff;
         OP_XFER:     sel_ff <= !sel_ff;
         OP_RESP: begin
            rsp_median_doubled <= median;
            rsp_element_count  <= COUNT_W'(total);
            rsp_dropped        <= drop_ff;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: design/running_median_two_heaps.sv
// Sequence: a refused word goes straight to the response state; others are answered after
//    the insertion sift, a level at a time, then, when the heaps are unbalanced, a rebalance
//    pop from the larger heap and the push of its old top into the other heap.
// Flow: one word in flight; the next is taken once the controller is back in idle, which it
//    enters as the result register loads, after any wait for the sink to free that register.
// Reset: synchronous, active high; clears both heap sizes, the controller and the result
//    valid flag. Heap contents are left as they are and need no clearing pass.
`default_nettype none
module running_median_two_heaps #(
   parameter int HEAP_DEPTH = rmth_pkg::HEAP_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   rmth_req_if.sink  req_chan,
   rmth_rsp_if.source rsp_chan
);
   import rmth_pkg::*;

   // The controller sequences every heap operation; the datapath holds both heap
   // memories, the cached tops, the sizes and the result register.
   cmd_type  cmd;
   stat_type stat;

   rmth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The result word sits in its own register, so the next word is taken as soon
   // as the controller is back in idle, even while the sink still stalls.
   rmth_dpath #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_value          (req_chan.value),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_median_doubled (rsp_chan.median_doubled),
      .rsp_element_count  (rsp_chan.element_count),
      .rsp_dropped        (rsp_chan.dropped)
   );

   // A dropped word is only ever reported with the store full.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.dropped) |->
         (rsp_chan.element_count == COUNT_W'(2 * HEAP_DEPTH - 1)))
      else $error("dropped word reported with store not full");

   // Once a word is taken, the controller leaves idle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input taken again without leaving idle");

   // Whenever idle, the heaps are balanced.
   a_balanced_idle: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !(stat.lower_big || stat.upper_big))
      else $error("heaps unbalanced while idle");

endmodule
`default_nettype wire
